// ===== src/oqr_pkg.sv =====
// oqr_pkg: shared widths, data types and pipeline control for the quad/rect overlap test
`default_nettype none
package oqr_pkg;

  // coordinate width (signed fixed point)
  localparam int COORD_BITS = 16;
  // edge normal component: difference of two coordinates
  localparam int DIFF_BITS  = COORD_BITS + 1;
  // coordinate times normal component, exact
  localparam int PROD_BITS  = COORD_BITS + DIFF_BITS;
  // sum of two products, exact
  localparam int DOT_BITS   = PROD_BITS + 1;
  // register stages from an accepted beat to the result strobe
  localparam int LATENCY    = 6;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [DOT_BITS-1:0]   dot_t;

  // control that travels with each beat down the pipeline
  typedef struct packed {
    logic valid;
    logic ext_ok;
  } ctl_t;

endpackage
`default_nettype wire

// ===== src/oqr_front.sv =====
// oqr_front: input register, quad extent test and edge normal computation
`default_nettype none
module oqr_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire oqr_pkg::coord_t in_qx [4],
  input  wire oqr_pkg::coord_t in_qy [4],
  input  wire oqr_pkg::coord_t in_left,
  input  wire oqr_pkg::coord_t in_top,
  input  wire oqr_pkg::coord_t in_right,
  input  wire oqr_pkg::coord_t in_bottom,
  output oqr_pkg::ctl_t        ctl,
  output oqr_pkg::coord_t      qx [4],
  output oqr_pkg::coord_t      qy [4],
  output oqr_pkg::coord_t      left,
  output oqr_pkg::coord_t      top,
  output oqr_pkg::coord_t      right,
  output oqr_pkg::coord_t      bottom,
  output oqr_pkg::diff_t       nx0,
  output oqr_pkg::diff_t       ny0,
  output oqr_pkg::diff_t       nx1,
  output oqr_pkg::diff_t       ny1
);

  function automatic oqr_pkg::coord_t cmin(oqr_pkg::coord_t a, oqr_pkg::coord_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic oqr_pkg::coord_t cmax(oqr_pkg::coord_t a, oqr_pkg::coord_t b);
    return (a > b) ? a : b;
  endfunction

  // stage 1 registers
  logic            v1;
  oqr_pkg::coord_t qx1 [4];
  oqr_pkg::coord_t qy1 [4];
  oqr_pkg::coord_t left1, top1, right1, bottom1;

  oqr_pkg::coord_t minx, maxx, miny, maxy;
  logic            ext_ok_next;
  oqr_pkg::diff_t  nx0_next, ny0_next, nx1_next, ny1_next;

  // capture the beat
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    qx1     <= in_qx;
    qy1     <= in_qy;
    left1   <= in_left;
    top1    <= in_top;
    right1  <= in_right;
    bottom1 <= in_bottom;
  end

  // quad bounding box against the rectangle edges as given
  always_comb begin
    minx = cmin(cmin(qx1[0], qx1[1]), cmin(qx1[2], qx1[3]));
    maxx = cmax(cmax(qx1[0], qx1[1]), cmax(qx1[2], qx1[3]));
    miny = cmin(cmin(qy1[0], qy1[1]), cmin(qy1[2], qy1[3]));
    maxy = cmax(cmax(qy1[0], qy1[1]), cmax(qy1[2], qy1[3]));
    ext_ok_next = (maxx > left1) && (minx < right1) && (maxy > top1) && (miny < bottom1);
  end

  // edge normals: edge turned by 90 degrees, (-dy, dx)
  always_comb begin
    nx0_next = oqr_pkg::diff_t'(qy1[0]) - oqr_pkg::diff_t'(qy1[1]);
    ny0_next = oqr_pkg::diff_t'(qx1[1]) - oqr_pkg::diff_t'(qx1[0]);
    nx1_next = oqr_pkg::diff_t'(qy1[1]) - oqr_pkg::diff_t'(qy1[2]);
    ny1_next = oqr_pkg::diff_t'(qx1[2]) - oqr_pkg::diff_t'(qx1[1]);
  end

  // stage 2 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl.valid  <= v1;
      ctl.ext_ok <= ext_ok_next;
    end
  end

  always_ff @(posedge clk) begin
    qx     <= qx1;
    qy     <= qy1;
    left   <= left1;
    top    <= top1;
    right  <= right1;
    bottom <= bottom1;
    nx0    <= nx0_next;
    ny0    <= ny0_next;
    nx1    <= nx1_next;
    ny1    <= ny1_next;
  end

endmodule
`default_nettype wire

// ===== src/oqr_project.sv =====
// oqr_project: projects quad and rectangle onto one axis, gives both intervals
`default_nettype none
module oqr_project (
  input  wire logic            clk,
  input  wire oqr_pkg::coord_t qx [4],
  input  wire oqr_pkg::coord_t qy [4],
  input  wire oqr_pkg::coord_t left,
  input  wire oqr_pkg::coord_t top,
  input  wire oqr_pkg::coord_t right,
  input  wire oqr_pkg::coord_t bottom,
  input  wire oqr_pkg::diff_t  nx,
  input  wire oqr_pkg::diff_t  ny,
  output oqr_pkg::dot_t        qmin,
  output oqr_pkg::dot_t        qmax,
  output oqr_pkg::dot_t        rmin,
  output oqr_pkg::dot_t        rmax
);

  function automatic oqr_pkg::prod_t pmin(oqr_pkg::prod_t a, oqr_pkg::prod_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic oqr_pkg::prod_t pmax(oqr_pkg::prod_t a, oqr_pkg::prod_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic oqr_pkg::dot_t dmin(oqr_pkg::dot_t a, oqr_pkg::dot_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic oqr_pkg::dot_t dmax(oqr_pkg::dot_t a, oqr_pkg::dot_t b);
    return (a > b) ? a : b;
  endfunction

  // stage 3: exact products
  oqr_pkg::prod_t px [4];
  oqr_pkg::prod_t py [4];
  oqr_pkg::prod_t pl, pr, pt, pb;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      px[i] <= oqr_pkg::prod_t'(qx[i]) * oqr_pkg::prod_t'(nx);
      py[i] <= oqr_pkg::prod_t'(qy[i]) * oqr_pkg::prod_t'(ny);
    end
    pl <= oqr_pkg::prod_t'(left)   * oqr_pkg::prod_t'(nx);
    pr <= oqr_pkg::prod_t'(right)  * oqr_pkg::prod_t'(nx);
    pt <= oqr_pkg::prod_t'(top)    * oqr_pkg::prod_t'(ny);
    pb <= oqr_pkg::prod_t'(bottom) * oqr_pkg::prod_t'(ny);
  end

  // stage 4: quad corner dots; rect extremes split per axis term
  oqr_pkg::dot_t dq [4];
  oqr_pkg::dot_t rmin4, rmax4;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      dq[i] <= oqr_pkg::dot_t'(px[i]) + oqr_pkg::dot_t'(py[i]);
    end
    rmin4 <= oqr_pkg::dot_t'(pmin(pl, pr)) + oqr_pkg::dot_t'(pmin(pt, pb));
    rmax4 <= oqr_pkg::dot_t'(pmax(pl, pr)) + oqr_pkg::dot_t'(pmax(pt, pb));
  end

  // stage 5: quad interval; the rect interval is passed through
  always_ff @(posedge clk) begin
    qmin <= dmin(dmin(dq[0], dq[1]), dmin(dq[2], dq[3]));
    qmax <= dmax(dmax(dq[0], dq[1]), dmax(dq[2], dq[3]));
    rmin <= rmin4;
    rmax <= rmax4;
  end

endmodule
`default_nettype wire

// ===== src/oriented_quad_rect_overlap.sv =====
// oriented_quad_rect_overlap: top level of the quad versus rectangle overlap pipeline
//
//   channel   signals                                 handshake
//   command   start, busy, quad_*, rect_*             beat taken when start && !busy
//   result    done, overlap                           one-cycle strobe, no back pressure
//
// one beat per cycle; busy is never raised
// a beat passes the front stages, the projection stages and the result register before done is raised
// the depth is set by the multiply stage and the compare trees on 34-bit dot products
// rst (synchronous) empties the pipeline; beats in flight are dropped
// the receiver cannot stall, so no beat is ever held back
`default_nettype none
module oriented_quad_rect_overlap (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire oqr_pkg::coord_t quad_x0,
  input  wire oqr_pkg::coord_t quad_y0,
  input  wire oqr_pkg::coord_t quad_x1,
  input  wire oqr_pkg::coord_t quad_y1,
  input  wire oqr_pkg::coord_t quad_x2,
  input  wire oqr_pkg::coord_t quad_y2,
  input  wire oqr_pkg::coord_t quad_x3,
  input  wire oqr_pkg::coord_t quad_y3,
  input  wire oqr_pkg::coord_t rect_left,
  input  wire oqr_pkg::coord_t rect_top,
  input  wire oqr_pkg::coord_t rect_right,
  input  wire oqr_pkg::coord_t rect_bottom,
  output logic                 done,
  output logic                 overlap
);

  oqr_pkg::coord_t in_qx [4];
  oqr_pkg::coord_t in_qy [4];
  oqr_pkg::coord_t qx [4];
  oqr_pkg::coord_t qy [4];
  oqr_pkg::coord_t left, top, right, bottom;
  oqr_pkg::diff_t  nx0, ny0, nx1, ny1;
  oqr_pkg::ctl_t   ctl2, ctl3, ctl4, ctl5;
  oqr_pkg::dot_t   qmin0, qmax0, rmin0, rmax0;
  oqr_pkg::dot_t   qmin1, qmax1, rmin1, rmax1;
  logic            hit;

  // the pipeline never holds a beat back
  assign busy = 1'b0;

  assign in_qx[0] = quad_x0;
  assign in_qx[1] = quad_x1;
  assign in_qx[2] = quad_x2;
  assign in_qx[3] = quad_x3;
  assign in_qy[0] = quad_y0;
  assign in_qy[1] = quad_y1;
  assign in_qy[2] = quad_y2;
  assign in_qy[3] = quad_y3;

  // stages 1-2: input capture, extent test, normals
  oqr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (start && !busy),
    .in_qx     (in_qx),
    .in_qy     (in_qy),
    .in_left   (rect_left),
    .in_top    (rect_top),
    .in_right  (rect_right),
    .in_bottom (rect_bottom),
    .ctl       (ctl2),
    .qx        (qx),
    .qy        (qy),
    .left      (left),
    .top       (top),
    .right     (right),
    .bottom    (bottom),
    .nx0       (nx0),
    .ny0       (ny0),
    .nx1       (nx1),
    .ny1       (ny1)
  );

  // stages 3-5: one projection unit per edge normal, for the edges from corner 0 to 1 and from corner 1 to 2
  oqr_project u_axis0 (
    .clk    (clk),
    .qx     (qx),
    .qy     (qy),
    .left   (left),
    .top    (top),
    .right  (right),
    .bottom (bottom),
    .nx     (nx0),
    .ny     (ny0),
    .qmin   (qmin0),
    .qmax   (qmax0),
    .rmin   (rmin0),
    .rmax   (rmax0)
  );

  oqr_project u_axis1 (
    .clk    (clk),
    .qx     (qx),
    .qy     (qy),
    .left   (left),
    .top    (top),
    .right  (right),
    .bottom (bottom),
    .nx     (nx1),
    .ny     (ny1),
    .qmin   (qmin1),
    .qmax   (qmax1),
    .rmin   (rmin1),
    .rmax   (rmax1)
  );

  // control follows the projection stages
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl3 <= '0;
      ctl4 <= '0;
      ctl5 <= '0;
    end else begin
      ctl3 <= ctl2;
      ctl4 <= ctl3;
      ctl5 <= ctl4;
    end
  end

  // strict interval overlap on both axes plus the extent test
  assign hit = ctl5.ext_ok
            && (rmin0 < qmax0) && (qmin0 < rmax0)
            && (rmin1 < qmax1) && (qmin1 < rmax1);

  // stage 6: result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done    <= 1'b0;
      overlap <= 1'b0;
    end else begin
      done    <= ctl5.valid;
      overlap <= ctl5.valid && hit;
    end
  end

`ifndef SYNTH
  // every accepted beat comes out as a result strobe
  a_latency : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##6 done)
    else $error("accepted beat gave no result strobe");

  // no strobe without an earlier accepted beat
  a_no_phantom : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, oqr_pkg::LATENCY))
    else $error("result strobe without an accepted beat");

  // an overlap never survives a failed extent test
  a_extent : assert property (@(posedge clk) disable iff (rst)
    overlap |-> $past(ctl5.ext_ok))
    else $error("overlap reported although the extents are apart");

  // overlap only shows together with the strobe
  a_gated : assert property (@(posedge clk) disable iff (rst)
    overlap |-> done)
    else $error("overlap high outside a result beat");
`endif

endmodule
`default_nettype wire
